// ----- rtl/tone_note_sequencer_unit_defines.svh -----
// Assertion helpers used by the sequencer RTL.
`ifndef TONE_NOTE_SEQUENCER_UNIT_DEFINES_SVH
`define TONE_NOTE_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while in reset.
`define TNS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet while in reset.
`define TNS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tns_pkg.sv -----
package tns_pkg;

    localparam int NOTE_DEPTH = 256;
    localparam int NOTE_AW    = $clog2(NOTE_DEPTH);
    localparam int LEN_W      = NOTE_AW + 1;
    localparam int GAP_TICKS  = 20;

    localparam logic [15:0] IDLE_FREQ = 16'd25;
    localparam logic [6:0]  VOL_MAX   = 7'd100;

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;
    localparam logic [1:0] REQ_STOP  = 2'd3;

    localparam logic [2:0] CFG_VOLUME      = 3'd0;
    localparam logic [2:0] CFG_TEMPO_MULT  = 3'd1;
    localparam logic [2:0] CFG_TEMPO_DIV   = 3'd2;
    localparam logic [2:0] CFG_SONG_LENGTH = 3'd3;
    localparam logic [2:0] CFG_REPEAT      = 3'd4;

    typedef struct packed {
        logic [15:0] freq;
        logic [15:0] dur;
    } note_entry_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

endpackage

// ----- rtl/tns_note_mem.sv -----
module tns_note_mem
    import tns_pkg::*;
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [NOTE_AW-1:0] wr_addr,
    input  note_entry_t        wr_data,
    input  logic               rd_en,
    input  logic [NOTE_AW-1:0] rd_addr,
    output note_entry_t        rd_data
);

    note_entry_t mem_reg [0:NOTE_DEPTH-1];
    note_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/tns_div.sv -----
module tns_div
    import tns_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  div_req_t    req,
    output logic        done,
    output logic [31:0] quotient
);

    // restoring divider, one quotient bit per cycle
    logic [31:0] dvd_reg, dvd_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] dvs_reg, dvs_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] trial;

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, dvd_reg[31]};
        if (req.start)
        begin
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
            rem_next  = '0;
            cnt_next  = 5'd31;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = 16'(trial - {1'b0, dvs_reg});
                dvd_next = {dvd_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = trial[15:0];
                dvd_next = {dvd_reg[30:0], 1'b0};
            end
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

// ----- rtl/tone_note_sequencer_unit.sv -----
// Tone note sequencer: plays a score held in a 256-entry note memory.
// Input channel (in_valid/in_stall): req_type selects tick, note write,
// start or stop; entry_index/entry_freq/entry_time carry a note write.
// Every accepted item gives exactly one result on the output channel
// (out_valid/out_stall): tone_freq, pulse_width, out_enable, is_playing.
// Configuration port (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; registers: volume, tempo_mult, tempo_div, song_length, repeat_count.
// An item that loads no note needs no memory read, multiply or divide. An
// item that loads a note (start, or the tick that ends a gap) takes a note
// memory read, a 16x16 multiply, then a bit-serial tempo divide in tns_div.
// One item is in work at a time; in_stall is high from acceptance until
// its result is in the output register. The output register frees the
// input side, so the next item is taken while a result waits there.
// While out_stall is high the finished result holds and a following
// result waits in the core. Reset stops playback, gives the idle tone and
// loads the register defaults; the note memory is not cleared.
module tone_note_sequencer_unit
    import tns_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [7:0]  entry_index,
    input  logic [15:0] entry_freq,
    input  logic [15:0] entry_time,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] tone_freq,
    output logic [6:0]  pulse_width,
    output logic        out_enable,
    output logic        is_playing,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

`include "tone_note_sequencer_unit_defines.svh"

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_MULT = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    localparam int GAP_AFTER = (GAP_TICKS > 0) ? GAP_TICKS - 1 : 0;

    logic [2:0]         state_reg, state_next;
    logic [6:0]         volume_reg;
    logic [15:0]        tempo_mult_reg, tempo_div_reg, repeat_count_reg;
    logic [8:0]         song_length_reg;

    logic               active_reg, active_next;
    logic               stop_after_reg, stop_after_next;
    logic               in_gap_reg, in_gap_next;
    logic [LEN_W-1:0]   note_pos_reg, note_pos_next;
    logic [31:0]        ticks_reg, ticks_next;
    logic [15:0]        repeats_reg, repeats_next;
    logic [15:0]        cur_freq_reg, cur_freq_next;
    logic [6:0]         cur_width_reg, cur_width_next;
    logic [NOTE_AW-1:0] pos_reg, pos_next;
    logic               dec_reg, dec_next;
    logic [31:0]        product_reg, product_next;

    logic               out_valid_reg, out_valid_next;
    logic [15:0]        tone_freq_reg;
    logic [6:0]         pulse_width_reg;
    logic               out_enable_reg, is_playing_reg;
    logic               out_load;

    logic               mem_wr, mem_rd;
    note_entry_t        mem_wdata, mem_rdata;
    div_req_t           div_req;
    logic               div_done;
    logic [31:0]        div_quo;

    logic [LEN_W-1:0]   len;
    logic [LEN_W-1:0]   load_pos;
    logic [LEN_W-1:0]   pos_inc;
    logic [6:0]         vol_sat;
    logic               go_load, load_dec;

    tns_note_mem u_mem (
        .clk     (clk),
        .wr_en   (mem_wr),
        .wr_addr (entry_index[NOTE_AW-1:0]),
        .wr_data (mem_wdata),
        .rd_en   (mem_rd),
        .rd_addr (load_pos[NOTE_AW-1:0]),
        .rd_data (mem_rdata)
    );

    tns_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign mem_wdata.freq = entry_freq;
    assign mem_wdata.dur  = entry_time;

    assign len = (LEN_W'(song_length_reg) > LEN_W'(NOTE_DEPTH)) ? LEN_W'(NOTE_DEPTH)
                                                              : LEN_W'(song_length_reg);
    // a start plays from note 0; a shrunk song wraps a stale position
    assign load_pos = ((req_type == REQ_START) || (note_pos_reg >= len)) ? '0 : note_pos_reg;
    assign pos_inc  = {1'b0, pos_reg} + LEN_W'(1);
    assign vol_sat  = (volume_reg > VOL_MAX) ? VOL_MAX : volume_reg;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next      = state_reg;
        active_next     = active_reg;
        stop_after_next = stop_after_reg;
        in_gap_next     = in_gap_reg;
        note_pos_next   = note_pos_reg;
        ticks_next      = ticks_reg;
        repeats_next    = repeats_reg;
        cur_freq_next   = cur_freq_reg;
        cur_width_next  = cur_width_reg;
        pos_next        = pos_reg;
        dec_next        = dec_reg;
        product_next    = product_reg;
        mem_wr          = 1'b0;
        mem_rd          = 1'b0;
        go_load         = 1'b0;
        load_dec        = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = product_reg;
        div_req.divisor  = (tempo_div_reg == 16'd0) ? 16'd1 : tempo_div_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DONE;
                    case (req_type)
                        REQ_TICK:
                        begin
                            if (active_reg)
                            begin
                                if (ticks_reg == 32'd0)
                                begin
                                    if (!in_gap_reg)
                                    begin
                                        in_gap_next    = 1'b1;
                                        ticks_next     = 32'(GAP_AFTER);
                                        cur_freq_next  = IDLE_FREQ;
                                        cur_width_next = '0;
                                    end
                                    else if (stop_after_reg)
                                    begin
                                        active_next     = 1'b0;
                                        stop_after_next = 1'b0;
                                        in_gap_next     = 1'b0;
                                        ticks_next      = '0;
                                        cur_freq_next   = IDLE_FREQ;
                                        cur_width_next  = '0;
                                    end
                                    else
                                    begin
                                        go_load  = 1'b1;
                                        load_dec = 1'b1;
                                    end
                                end
                                else
                                begin
                                    ticks_next = ticks_reg - 32'd1;
                                end
                            end
                        end
                        REQ_WRITE:
                        begin
                            mem_wr = ({1'b0, entry_index} < 9'(NOTE_DEPTH));
                        end
                        REQ_START:
                        begin
                            stop_after_next = 1'b0;
                            in_gap_next     = 1'b0;
                            ticks_next      = '0;
                            cur_freq_next   = IDLE_FREQ;
                            cur_width_next  = '0;
                            note_pos_next   = '0;
                            repeats_next    = repeat_count_reg;
                            active_next     = 1'b1;
                            go_load         = 1'b1;
                        end
                        REQ_STOP:
                        begin
                            active_next     = 1'b0;
                            stop_after_next = 1'b0;
                            in_gap_next     = 1'b0;
                            ticks_next      = '0;
                            cur_freq_next   = IDLE_FREQ;
                            cur_width_next  = '0;
                        end
                        default:
                        begin
                        end
                    endcase

                    if (go_load)
                    begin
                        if (len == '0)
                        begin
                            // empty song stops at once
                            active_next     = 1'b0;
                            stop_after_next = 1'b0;
                            in_gap_next     = 1'b0;
                            ticks_next      = '0;
                            cur_freq_next   = IDLE_FREQ;
                            cur_width_next  = '0;
                        end
                        else
                        begin
                            mem_rd     = 1'b1;
                            pos_next   = load_pos[NOTE_AW-1:0];
                            dec_next   = load_dec;
                            state_next = S_READ;
                        end
                    end
                end
            end
            S_READ:
            begin
                product_next = 32'(mem_rdata.dur) * 32'(tempo_mult_reg);
                in_gap_next  = 1'b0;
                if ((mem_rdata.freq != 16'd0) && (vol_sat != 7'd0))
                begin
                    cur_freq_next  = mem_rdata.freq;
                    cur_width_next = vol_sat;
                end
                else
                begin
                    cur_freq_next  = IDLE_FREQ;
                    cur_width_next = '0;
                end
                if (pos_inc >= len)
                begin
                    if (repeats_reg != 16'd0)
                    begin
                        note_pos_next = '0;
                        repeats_next  = repeats_reg - 16'd1;
                    end
                    else
                    begin
                        note_pos_next   = pos_inc;
                        stop_after_next = 1'b1;
                    end
                end
                else
                begin
                    note_pos_next = pos_inc;
                end
                state_next = S_MULT;
            end
            S_MULT:
            begin
                div_req.start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    // a tick that loads a note also counts itself
                    ticks_next = (dec_reg && (div_quo != 32'd0)) ? div_quo - 32'd1 : div_quo;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            active_reg     <= 1'b0;
            stop_after_reg <= 1'b0;
            in_gap_reg     <= 1'b0;
            note_pos_reg   <= '0;
            ticks_reg      <= '0;
            repeats_reg    <= '0;
            cur_freq_reg   <= IDLE_FREQ;
            cur_width_reg  <= '0;
            dec_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            active_reg     <= active_next;
            stop_after_reg <= stop_after_next;
            in_gap_reg     <= in_gap_next;
            note_pos_reg   <= note_pos_next;
            ticks_reg      <= ticks_next;
            repeats_reg    <= repeats_next;
            cur_freq_reg   <= cur_freq_next;
            cur_width_reg  <= cur_width_next;
            dec_reg        <= dec_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        product_reg <= product_next;
        if (out_load)
        begin
            tone_freq_reg   <= cur_freq_reg;
            pulse_width_reg <= cur_width_reg;
            out_enable_reg  <= active_reg;
            is_playing_reg  <= active_reg && !stop_after_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_reg       <= 7'd25;
            tempo_mult_reg   <= 16'd1;
            tempo_div_reg    <= 16'd1;
            song_length_reg  <= '0;
            repeat_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_VOLUME:      volume_reg       <= cfg_data[6:0];
                CFG_TEMPO_MULT:  tempo_mult_reg   <= cfg_data;
                CFG_TEMPO_DIV:   tempo_div_reg    <= cfg_data;
                CFG_SONG_LENGTH: song_length_reg  <= cfg_data[8:0];
                CFG_REPEAT:      repeat_count_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg_ready   = 1'b1;
    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign tone_freq   = tone_freq_reg;
    assign pulse_width = pulse_width_reg;
    assign out_enable  = out_enable_reg;
    assign is_playing  = is_playing_reg;

    `TNS_ASSERT_IMPLY(a_playing_needs_enable, out_valid && is_playing, out_enable,
        "is_playing without out_enable")
    `TNS_ASSERT_IMPLY(a_silent_is_idle, out_valid && !out_enable,
        (tone_freq == IDLE_FREQ) && (pulse_width == 7'd0), "silent output not idle tone")
    `TNS_ASSERT_NEXT(a_stop_clears, in_valid && !in_stall && (req_type == REQ_STOP),
        !active_reg && !in_gap_reg && (ticks_reg == 32'd0), "stop transfer left state active")
    `TNS_ASSERT_IMPLY(a_div_done_in_div, div_done, state_reg == S_DIV,
        "divider finished outside divide state")

endmodule

// ----- sim/tone_note_sequencer_unit_test.sv -----
`timescale 1ns / 100ps

module tone_note_sequencer_unit_test;
    import tns_pkg::*;

    localparam int TOTAL_REQS  = 1700;
    localparam int CALM_TAIL   = 300;
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_WAIT  = 40;

    typedef struct packed {
        logic [15:0] freq;
        logic [6:0]  width;
        logic        enable;
        logic        playing;
    } tone_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  req_type = REQ_TICK;
    logic [7:0]  entry_index = '0;
    logic [15:0] entry_freq = '0;
    logic [15:0] entry_time = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] tone_freq;
    logic [6:0]  pulse_width;
    logic        out_enable;
    logic        is_playing;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = CFG_VOLUME;
    logic [15:0] cfg_data = '0;

    tone_note_sequencer_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .entry_index (entry_index),
        .entry_freq  (entry_freq),
        .entry_time  (entry_time),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .tone_freq   (tone_freq),
        .pulse_width (pulse_width),
        .out_enable  (out_enable),
        .is_playing  (is_playing),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #6 clk = ~clk;

    // sequencer state as the score player sees it
    logic [15:0] score_freq [NOTE_DEPTH];
    logic [15:0] score_time [NOTE_DEPTH];
    logic [6:0]  set_volume;
    logic [15:0] set_mult;
    logic [15:0] set_div;
    logic [8:0]  set_length;
    logic [15:0] set_repeat;
    bit          playing_on;
    bit          last_loaded;
    bit          gap_phase;
    logic [8:0]  cursor;
    logic [31:0] ticks_left;
    logic [15:0] passes_left;
    logic [15:0] held_freq;
    logic [6:0]  held_width;

    tone_t expected_tones [$];
    int    fault_count = 0;
    int    quiet_cycles = 0;
    int    reqs_sent = 0;
    int    hold_left = 0;
    bit    idling_on = 1'b1;

    function automatic void go_silent();
        playing_on  = 1'b0;
        last_loaded = 1'b0;
        gap_phase   = 1'b0;
        ticks_left  = '0;
        held_freq   = IDLE_FREQ;
        held_width  = '0;
    endfunction

    function automatic void load_next_note();
        logic [8:0]  len;
        logic [6:0]  vol;
        logic [15:0] div;
        logic [63:0] prod;
        len = (set_length > NOTE_DEPTH) ? 9'(NOTE_DEPTH) : set_length;
        if (len == 0) begin
            go_silent();
        end
        else begin
            vol = (set_volume > VOL_MAX) ? VOL_MAX : set_volume;
            div = (set_div == 0) ? 16'd1 : set_div;
            if (cursor >= len)
                cursor = '0;
            prod = 64'(score_time[cursor[7:0]]) * 64'(set_mult) / 64'(div);
            ticks_left = prod[31:0];
            gap_phase = 1'b0;
            if (score_freq[cursor[7:0]] != 0 && vol != 0) begin
                held_freq  = score_freq[cursor[7:0]];
                held_width = vol;
            end
            else begin
                held_freq  = IDLE_FREQ;
                held_width = '0;
            end
            cursor = cursor + 9'd1;
            if (cursor >= len) begin
                if (passes_left != 0) begin
                    cursor = '0;
                    passes_left = passes_left - 16'd1;
                end
                else begin
                    last_loaded = 1'b1;
                end
            end
        end
    endfunction

    function automatic void advance_tick();
        if (playing_on) begin
            if (ticks_left == 0) begin
                if (!gap_phase) begin
                    gap_phase  = 1'b1;
                    ticks_left = GAP_TICKS;
                    held_freq  = IDLE_FREQ;
                    held_width = '0;
                end
                else if (last_loaded) begin
                    go_silent();
                end
                else begin
                    load_next_note();
                end
            end
            // go_silent leaves ticks_left at zero, so this is safe either way
            if (ticks_left != 0)
                ticks_left = ticks_left - 32'd1;
        end
    endfunction

    function automatic tone_t next_tone(input logic [1:0] kind, input logic [7:0] idx,
                                        input logic [15:0] f, input logic [15:0] t);
        case (kind)
            REQ_TICK: advance_tick();
            REQ_WRITE:
            begin
                score_freq[idx] = f;
                score_time[idx] = t;
            end
            REQ_START:
            begin
                go_silent();
                cursor = '0;
                passes_left = set_repeat;
                playing_on = 1'b1;
                load_next_note();
            end
            default: go_silent();
        endcase
        return '{held_freq, held_width, playing_on, playing_on && !last_loaded};
    endfunction

    function automatic void apply_reg(input logic [2:0] slot, input logic [15:0] value);
        case (slot)
            CFG_VOLUME:      set_volume = value[6:0];
            CFG_TEMPO_MULT:  set_mult   = value;
            CFG_TEMPO_DIV:   set_div    = value;
            CFG_SONG_LENGTH: set_length = value[8:0];
            CFG_REPEAT:      set_repeat = value;
            default: ;
        endcase
    endfunction

    function automatic void count_fault(input string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("%0t: %s", $time, msg);
    endfunction

    function automatic logic [15:0] rnd_freq();
        return ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom);
    endfunction

    // mostly short notes so the score gets through a few stages
    function automatic logic [15:0] rnd_dur();
        return ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
    endfunction

    // receiver side: random stall bursts
    always @(posedge clk) begin
        if (idling_on && hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (idling_on && $urandom_range(0, 11) == 0) begin
            hold_left <= $urandom_range(0, 11);
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= 1'b0;
        end
    end

    // result check: sampled mid-cycle, the transfer happens at the next rising edge
    always @(negedge clk) begin : tone_check
        tone_t got;
        tone_t want;
        if (rst_n && out_valid && !out_stall) begin
            quiet_cycles = 0;
            got = '{tone_freq, pulse_width, out_enable, is_playing};
            if (expected_tones.size() == 0) begin
                count_fault($sformatf("unexpected result freq %0d width %0d en %b play %b",
                                      got.freq, got.width, got.enable, got.playing));
            end
            else begin
                want = expected_tones.pop_front();
                if (got.freq !== want.freq || got.width !== want.width ||
                    got.enable !== want.enable || got.playing !== want.playing)
                    count_fault($sformatf({"tone mismatch: exp freq %0d width %0d en %b play %b,",
                                           " got freq %0d width %0d en %b play %b"},
                                          want.freq, want.width, want.enable, want.playing,
                                          got.freq, got.width, got.enable, got.playing));
            end
        end
    end

    always @(posedge clk) begin
        quiet_cycles++;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("tone_note_sequencer_unit_test: done, errors");
            $finish;
        end
    end

    // valid is left high after a transfer; whoever goes quiet next lowers it
    task automatic issue_req(input logic [1:0] kind, input logic [7:0] idx,
                             input logic [15:0] f, input logic [15:0] t);
        int  gap;
        bit  held;
        if (idling_on && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= kind;
        entry_index <= idx;
        entry_freq  <= f;
        entry_time  <= t;
        do begin
            @(negedge clk);
            held = in_stall;
            @(posedge clk);
        end while (held);
        quiet_cycles = 0;
        expected_tones.push_back(next_tone(kind, idx, f, t));
        reqs_sent++;
    endtask

    task automatic send_tick();
        issue_req(REQ_TICK, 8'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic send_cmd(input logic [1:0] kind);
        issue_req(kind, 8'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (expected_tones.size() != 0)
            @(posedge clk);
    endtask

    task automatic program_regs(input logic [15:0] vol, input logic [15:0] mult,
                                input logic [15:0] div, input logic [15:0] len,
                                input logic [15:0] rep);
        logic [15:0] vals [5];
        logic [2:0]  slots [5];
        bit          rdy;
        vals  = '{vol, mult, div, len, rep};
        slots = '{CFG_VOLUME, CFG_TEMPO_MULT, CFG_TEMPO_DIV, CFG_SONG_LENGTH, CFG_REPEAT};
        wait_for_results();
        for (int i = 0; i < 5; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= slots[i];
            cfg_data  <= vals[i];
            do begin
                @(negedge clk);
                rdy = cfg_ready;
                @(posedge clk);
            end while (!rdy);
            quiet_cycles = 0;
            apply_reg(slots[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_ticks(input int most, input bit noisy);
        int n;
        n = 0;
        while (playing_on && n < most) begin
            if (noisy && $urandom_range(0, 39) == 0)
                issue_req(REQ_WRITE, 8'($urandom), rnd_freq(), rnd_dur());
            else if (noisy && $urandom_range(0, 79) == 0)
                send_cmd(REQ_START);
            else if (noisy && $urandom_range(0, 119) == 0)
                send_cmd(REQ_STOP);
            else
                send_tick();
            n++;
        end
    endtask

    // tick, stop and start with no song loaded
    task automatic test_idle_requests();
        send_tick();
        send_cmd(REQ_STOP);
        send_cmd(REQ_START);
        send_tick();
    endtask

    // short score with a rest and a zero-length note, played twice to the end
    task automatic test_score_playback();
        issue_req(REQ_WRITE, 8'd0, 16'd440, 16'd2);
        issue_req(REQ_WRITE, 8'd1, 16'd0, 16'd1);
        issue_req(REQ_WRITE, 8'd2, 16'hFFFF, 16'd0);
        issue_req(REQ_WRITE, 8'hFF, 16'd1, 16'hFFFF);
        // volume saturates, zero divisor counts as one
        program_regs(16'd127, 16'd3, 16'd0, 16'd3, 16'd1);
        send_cmd(REQ_START);
        run_ticks(400, 1'b0);
        send_tick();
    endtask

    // zero volume, extreme tempo, stop in a note, restart in a gap and while playing
    task automatic test_stop_restart();
        program_regs(16'd0, 16'hFFFF, 16'hFFFF, 16'd3, 16'd2);
        send_cmd(REQ_START);
        run_ticks(2, 1'b0);
        send_cmd(REQ_STOP);
        send_tick();
        program_regs(16'd100, 16'd1, 16'd1, 16'd3, 16'hFFFF);
        send_cmd(REQ_START);
        run_ticks(25, 1'b0);
        send_cmd(REQ_START);
        run_ticks(3, 1'b0);
        send_cmd(REQ_STOP);
    endtask

    // whole note table, length past the table and at the table size
    task automatic test_full_score();
        for (int i = 0; i < NOTE_DEPTH; i++)
            issue_req(REQ_WRITE, 8'(i), rnd_freq(), 16'($urandom));
        program_regs(16'd64, 16'd1, 16'hFFFF, 16'd300, 16'd0);
        send_cmd(REQ_START);
        run_ticks(120, 1'b0);
        send_cmd(REQ_STOP);
        program_regs(16'd100, 16'd1, 16'hFFFF, 16'(NOTE_DEPTH), 16'd1);
        send_cmd(REQ_START);
        run_ticks(60, 1'b0);
        send_cmd(REQ_STOP);
    endtask

    // random songs until the whole run has sent about TOTAL_REQS items
    task automatic test_random_songs();
        int          stop_at;
        int          pick;
        int          writes;
        logic [15:0] vol, mult, div, len, rep;
        stop_at = TOTAL_REQS;
        while (reqs_sent < stop_at) begin
            if (stop_at - reqs_sent < CALM_TAIL)
                idling_on = 1'b0;
            else
                idling_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 9);
            vol = (pick == 0) ? 16'd0 : (pick == 1) ? 16'($urandom_range(101, 127))
                                                    : 16'($urandom_range(1, 100));
            pick = $urandom_range(0, 5);
            if (pick == 4) begin
                mult = 16'($urandom_range(1, 65535));
                div  = 16'($urandom);
            end
            else begin
                mult = 16'($urandom_range(1, 3));
                div  = (pick == 5) ? 16'd0 : 16'($urandom_range(1, 3));
            end
            pick = $urandom_range(0, 11);
            len = (pick == 0) ? 16'd0 : (pick == 1) ? 16'($urandom_range(257, 511)) :
                  (pick == 2) ? 16'($urandom_range(1, 256)) : 16'($urandom_range(1, 6));
            pick = $urandom_range(0, 9);
            rep = (pick == 0) ? 16'($urandom) : (pick == 1) ? 16'hFFFF
                                                            : 16'($urandom_range(0, 2));
            program_regs(vol, mult, div, len, rep);
            writes = $urandom_range(0, 4);
            repeat (writes)
                issue_req(REQ_WRITE, 8'($urandom), rnd_freq(), rnd_dur());
            if ($urandom_range(0, 9) == 0)
                send_tick();
            if ($urandom_range(0, 9) == 0)
                send_cmd(REQ_STOP);
            send_cmd(REQ_START);
            run_ticks($urandom_range(20, 160), 1'b1);
            if (playing_on && $urandom_range(0, 1) == 0)
                send_cmd(REQ_STOP);
        end
    endtask

    initial begin
        set_volume  = 7'd25;
        set_mult    = 16'd1;
        set_div     = 16'd1;
        set_length  = '0;
        set_repeat  = '0;
        cursor      = '0;
        passes_left = '0;
        go_silent();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_requests();
        test_score_playback();
        test_stop_restart();
        test_full_score();
        test_random_songs();
        wait_for_results();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fault_count == 0 && expected_tones.size() == 0)
            $display("tone_note_sequencer_unit_test: done, clean");
        else
            $display("tone_note_sequencer_unit_test: done, errors");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/tns_pkg.sv
rtl/tns_note_mem.sv
rtl/tns_div.sv
rtl/tone_note_sequencer_unit.sv
sim/tone_note_sequencer_unit_test.sv
